// ===== rtl/fpa_pkg.sv =====
// shared constants and word types of the q24.8 fixed-point alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int OP_BITS   = 4;
    localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;

    localparam logic [OP_BITS-1:0] OP_ADD      = 4'd0;
    localparam logic [OP_BITS-1:0] OP_SUB      = 4'd1;
    localparam logic [OP_BITS-1:0] OP_MUL      = 4'd2;
    localparam logic [OP_BITS-1:0] OP_DIV      = 4'd3;
    localparam logic [OP_BITS-1:0] OP_CMP      = 4'd4;
    localparam logic [OP_BITS-1:0] OP_INC      = 4'd5;
    localparam logic [OP_BITS-1:0] OP_DEC      = 4'd6;
    localparam logic [OP_BITS-1:0] OP_MIN      = 4'd7;
    localparam logic [OP_BITS-1:0] OP_MAX      = 4'd8;
    localparam logic [OP_BITS-1:0] OP_FROM_INT = 4'd9;
    localparam logic [OP_BITS-1:0] OP_TO_INT   = 4'd10;

    typedef struct packed {
        logic [OP_BITS-1:0]          operation;
        logic signed [WORD_BITS-1:0] a_value;
        logic                        a_overflow;
        logic signed [WORD_BITS-1:0] b_value;
        logic                        b_overflow;
    } in_word_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] result_value;
        logic                        result_overflow;
        logic                        is_less;
        logic                        is_equal;
        logic                        is_greater;
    } out_word_t;

endpackage

`default_nettype wire

// ===== rtl/fixed_point_alu_q24_8.sv =====
// q24.8 fixed-point alu, fully pipelined with a one-bit-per-stage divider
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel   valid      stall      word
// operand   op_valid   op_stall   op_word  (fpa_pkg::in_word_t)
// result    res_valid  res_stall  res_word (fpa_pkg::out_word_t)
//
// one word per cycle while the result is not stalled; every operation passes through
// the input and setup registers, 40 restoring-division stages and the output
// register.
// reset clears the valid bits only; the data registers keep their contents.
// a stalled result freezes the whole pipe, so op_stall follows res_stall while res_valid is high.
module fixed_point_alu_q24_8 (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                op_valid,
    output logic                     op_stall,
    input  wire fpa_pkg::in_word_t   op_word,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output fpa_pkg::out_word_t       res_word
);

    localparam int W  = fpa_pkg::WORD_BITS;
    localparam int F  = fpa_pkg::FRAC_BITS;
    localparam int QB = fpa_pkg::QUO_BITS;

    typedef struct packed {
        logic          valid;
        logic          is_div;
        logic [W-1:0]  res;
        logic          ov;
        logic          lt;
        logic          eq;
        logic          gt;
        logic [W-1:0]  rem;
        logic [QB-1:0] dq;
        logic [W-1:0]  dvs;
        logic          neg;
    } pipe_t;

    function automatic pipe_t div_step(input pipe_t p);
        pipe_t      q;
        logic [W:0] t;
        q = p;
        t = {p.rem, p.dq[QB-1]} - {1'b0, p.dvs};
        if (!t[W])
        begin
            q.rem = t[W-1:0];
            q.dq  = {p.dq[QB-2:0], 1'b1};
        end
        else
        begin
            q.rem = {p.rem[W-2:0], p.dq[QB-1]};
            q.dq  = {p.dq[QB-2:0], 1'b0};
        end
        return q;
    endfunction

    logic en;
    assign en       = !res_valid || !res_stall;
    assign op_stall = !en;

    logic              s0_valid_reg;
    fpa_pkg::in_word_t s0_word_reg;

    pipe_t                 s1_reg, s1_next;
    logic signed [2*W-1:0] s1_prod_reg, s1_prod_next;
    logic                  s1_is_mul_reg, s1_is_mul_next;

    pipe_t div_reg  [QB];
    pipe_t div_next [QB];

    logic               res_valid_reg, res_valid_next;
    fpa_pkg::out_word_t res_word_reg, res_word_next;

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // operand setup and single-step operations
    always_comb
    begin
        logic signed [W-1:0] a, b;
        logic                af, bf, a_ge_b;
        logic [W:0]          sum;
        logic [W-1:0]        mag_a, mag_b;
        a      = s0_word_reg.a_value;
        b      = s0_word_reg.b_value;
        af     = s0_word_reg.a_overflow;
        bf     = s0_word_reg.b_overflow;
        a_ge_b = a >= b;
        mag_a  = a[W-1] ? (~a + 1'b1) : a;
        mag_b  = b[W-1] ? (~b + 1'b1) : b;
        sum    = '0;
        s1_next        = '0;
        s1_next.valid  = s0_valid_reg;
        s1_is_mul_next = 1'b0;
        s1_prod_next   = a * b;
        unique case (s0_word_reg.operation)
            fpa_pkg::OP_ADD:
            begin
                sum = {a[W-1], a} + {b[W-1], b};
                s1_next.res = sum[W-1:0];
                s1_next.ov  = (sum[W] != sum[W-1]) || af || bf;
            end
            fpa_pkg::OP_SUB:
            begin
                sum = {a[W-1], a} - {b[W-1], b};
                s1_next.res = sum[W-1:0];
                s1_next.ov  = (sum[W] != sum[W-1]) || af || bf;
            end
            fpa_pkg::OP_MUL:
            begin
                s1_is_mul_next = 1'b1;
                s1_next.ov     = af || bf;
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == '0)
                begin
                    s1_next.ov = 1'b1;
                end
                else
                begin
                    s1_next.is_div = 1'b1;
                    s1_next.ov     = af || bf;
                    s1_next.dq     = {mag_a, {F{1'b0}}};
                    s1_next.dvs    = mag_b;
                    s1_next.neg    = a[W-1] ^ b[W-1];
                end
            end
            fpa_pkg::OP_CMP:
            begin
                s1_next.lt = a < b;
                s1_next.eq = a == b;
                s1_next.gt = a > b;
            end
            fpa_pkg::OP_INC:
            begin
                s1_next.res = a + 1'b1;
                s1_next.ov  = (a == {1'b0, {(W-1){1'b1}}}) || af;
            end
            fpa_pkg::OP_DEC:
            begin
                s1_next.res = a - 1'b1;
                s1_next.ov  = (a == {1'b1, {(W-1){1'b0}}}) || af;
            end
            fpa_pkg::OP_MIN:
            begin
                s1_next.res = a_ge_b ? b : a;
                s1_next.ov  = a_ge_b ? bf : af;
            end
            fpa_pkg::OP_MAX:
            begin
                s1_next.res = a_ge_b ? a : b;
                s1_next.ov  = a_ge_b ? af : bf;
            end
            fpa_pkg::OP_FROM_INT:
            begin
                s1_next.res = {a[W-F-1:0], {F{1'b0}}};
                s1_next.ov  = (a[W-1:W-F-1] != {(F+1){a[W-1]}}) || af;
            end
            fpa_pkg::OP_TO_INT:
            begin
                // truncate toward zero: bump negative values with a nonzero fraction
                s1_next.res = W'(a >>> F)
                              + W'(a[W-1] && (a[F-1:0] != '0));
                s1_next.ov  = af;
            end
            default:
            begin
                s1_next.valid = s0_valid_reg;
            end
        endcase
    end

    // first divider stage also finishes the multiply
    always_comb
    begin
        pipe_t p;
        p = s1_reg;
        if (s1_is_mul_reg)
        begin
            p.res = s1_prod_reg[W+F-1:F];
            p.ov  = s1_reg.ov || (s1_prod_reg[2*W-1:W+F-1] != {(W-F+1){s1_prod_reg[W+F-1]}});
        end
        div_next[0] = div_step(p);
        for (int k = 1; k < QB; k++)
        begin
            div_next[k] = div_step(div_reg[k-1]);
        end
    end

    // sign and range of the quotient; other results pass through unchanged
    always_comb
    begin
        pipe_t        p;
        logic [W-1:0] q;
        logic         hi;
        p  = div_reg[QB-1];
        q  = p.dq[W-1:0];
        hi = p.dq[QB-1:W-1] != '0;
        res_valid_next = p.valid;
        res_word_next.is_less    = p.lt;
        res_word_next.is_equal   = p.eq;
        res_word_next.is_greater = p.gt;
        if (p.is_div)
        begin
            res_word_next.result_value    = p.neg ? (~q + 1'b1) : q;
            res_word_next.result_overflow = p.ov ||
                (p.neg ? (hi && (p.dq != {{(QB-W){1'b0}}, 1'b1, {(W-1){1'b0}}})) : hi);
        end
        else
        begin
            res_word_next.result_value    = p.res;
            res_word_next.result_overflow = p.ov;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_reg.valid  <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int k = 0; k < QB; k++)
            begin
                div_reg[k].valid <= 1'b0;
            end
        end
        else if (en)
        begin
            s0_valid_reg  <= op_valid;
            s0_word_reg   <= op_word;
            s1_reg        <= s1_next;
            s1_prod_reg   <= s1_prod_next;
            s1_is_mul_reg <= s1_is_mul_next;
            res_valid_reg <= res_valid_next;
            res_word_reg  <= res_word_next;
            for (int k = 0; k < QB; k++)
            begin
                div_reg[k] <= div_next[k];
            end
        end
    end

endmodule

`default_nettype wire
